FILE: rtl/plm_pkg.sv
// ---------------------------------------------------------------------------
// Point list merge package
// Shared types, constants and the microcode program of the point list merge.
// ---------------------------------------------------------------------------
package plm_pkg;

    // Default table depth and merge radius after reset (1.5 ft in Q8.8).
    localparam int          CAPACITY_DEF   = 16;
    localparam logic [15:0] MERGE_DIST_RST = 16'd384;

    // Output field widths.
    localparam int SLOT_OUT_W  = 4;
    localparam int CNT_OUT_W   = 5;

    // Table selector codes.
    localparam logic KIND_OBSTACLE = 1'b0;
    localparam logic KIND_HIKER    = 1'b1;

    // Microcode step counter and step addresses.
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [UPC_W-1:0] STEP_SETUP  = 3'd1;
    localparam logic [UPC_W-1:0] STEP_READ   = 3'd2;
    localparam logic [UPC_W-1:0] STEP_SQUARE = 3'd3;
    localparam logic [UPC_W-1:0] STEP_DECIDE = 3'd4;
    localparam logic [UPC_W-1:0] STEP_FINISH = 3'd5;

    // Datapath operations driven by one control word.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SETUP,
        OP_READ,
        OP_SQUARE,
        OP_DECIDE,
        OP_FINISH
    } t_op;

    // Jump conditions; when a condition holds the jump target is taken.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_START,
        COND_EMPTY,
        COND_NOT_LAST
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_ctrl_word;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op  op;
        logic load;
    } t_dp_ctrl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_status;

    // Microcode program: scan the chosen table one entry per three steps.
    function automatic t_ctrl_word ucode_fetch(input logic [UPC_W-1:0] upc);
        t_ctrl_word w;
        begin
            case (upc)
                STEP_IDLE:   w = '{op: OP_IDLE,   cond: COND_NOT_START, target: STEP_IDLE};
                STEP_SETUP:  w = '{op: OP_SETUP,  cond: COND_EMPTY,     target: STEP_FINISH};
                STEP_READ:   w = '{op: OP_READ,   cond: COND_NEVER,     target: STEP_IDLE};
                STEP_SQUARE: w = '{op: OP_SQUARE, cond: COND_NEVER,     target: STEP_IDLE};
                STEP_DECIDE: w = '{op: OP_DECIDE, cond: COND_NOT_LAST,  target: STEP_READ};
                STEP_FINISH: w = '{op: OP_FINISH, cond: COND_ALWAYS,    target: STEP_IDLE};
                default:     w = '{op: OP_IDLE,   cond: COND_ALWAYS,    target: STEP_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/plm_sequencer.sv
// ---------------------------------------------------------------------------
// Point list merge sequencer
// Step counter over the microcode table with conditional jumps.
// ---------------------------------------------------------------------------
module plm_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  plm_pkg::t_dp_status i_status,
    output plm_pkg::t_dp_ctrl  o_ctrl,
    output logic               o_busy
);
    import plm_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl_word       word;
    logic             jump;

    // Fetch the control word of the current step.
    assign word = ucode_fetch(r_upc);

    // Evaluate the jump condition of this step.
    always_comb begin
        case (word.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NOT_START: jump = !i_start;
            COND_EMPTY:     jump = i_status.empty;
            COND_NOT_LAST:  jump = !i_status.last;
            default:        jump = 1'b1;
        endcase
    end

    assign n_upc = jump ? word.target : r_upc + UPC_W'(1);

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // A request is taken only in the idle step.
    assign o_busy      = (r_upc != STEP_IDLE);
    assign o_ctrl.op   = word.op;
    assign o_ctrl.load = (r_upc == STEP_IDLE) && i_start;

`ifndef SYNTHESIS
    // An accepted request always moves on to the set-up step.
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_upc == STEP_SETUP))
        else $error("accepted request did not enter set-up");

    // The step counter never leaves the program.
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= STEP_FINISH)
        else $error("step counter outside program");

    // Every finish step returns to idle.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == STEP_FINISH) |=> (r_upc == STEP_IDLE))
        else $error("finish step did not return to idle");
`endif

endmodule

FILE: rtl/plm_datapath.sv
// ---------------------------------------------------------------------------
// Point list merge datapath
// Point tables, distance squares, compare and in-place compaction.
// ---------------------------------------------------------------------------
module plm_datapath #(
    parameter int CAPACITY = plm_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plm_pkg::t_dp_ctrl                   i_ctrl,
    input  logic                                i_cfg_wr_en,
    input  logic [15:0]                         i_cfg_wr_data,
    input  logic                                i_kind,
    input  logic signed [15:0]                  i_pos_x,
    input  logic signed [15:0]                  i_pos_y,
    output plm_pkg::t_dp_status                 o_status,
    output logic                                o_done,
    output logic                                o_merged,
    output logic                                o_dropped_full,
    output logic [plm_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic [plm_pkg::SLOT_OUT_W-1:0]      o_removed,
    output logic [plm_pkg::CNT_OUT_W-1:0]       o_entry_count
);
    import plm_pkg::*;

    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // Table storage: x in the upper half of a word, y in the lower half.
    logic [31:0] mem [MEM_DEPTH];

    logic [15:0]         r_merge_dist;
    logic                r_kind;
    logic signed [15:0]  r_px;
    logic signed [15:0]  r_py;
    logic [31:0]         r_limit;
    logic [31:0]         r_rd_data;
    logic [31:0]         r_sq_x;
    logic [31:0]         r_sq_y;
    logic [CNT_W-1:0]    r_rd;
    logic [CNT_W-1:0]    r_wr;
    logic [CNT_W-1:0]    r_count [2];
    logic                r_merged;
    logic [IDX_W-1:0]    r_slot;
    logic [IDX_W-1:0]    r_removed;
    logic                r_done;
    logic                r_out_merged;
    logic                r_out_dropped;
    logic [IDX_W-1:0]    r_out_slot;
    logic [IDX_W-1:0]    r_out_removed;
    logic [CNT_W-1:0]    r_out_count;

    logic [CNT_W-1:0]    cur_count;
    logic signed [16:0]  dx;
    logic signed [16:0]  dy;
    logic [16:0]         ax;
    logic [16:0]         ay;
    logic [32:0]         dist2;
    logic                hit;
    logic                full;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [31:0]         mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_pad;
    logic [IDX_W+SLOT_OUT_W-1:0] removed_pad;
    logic [CNT_W+CNT_OUT_W-1:0]  count_pad;

    assign cur_count = r_count[r_kind];

    // Status for the sequencer's jumps.
    assign o_status.empty = (cur_count == '0);
    assign o_status.last  = ((r_rd + CNT_W'(1)) == cur_count);

    // Differences and magnitudes of the entry just read.
    assign dx = 17'(r_px) - 17'($signed(r_rd_data[31:16]));
    assign dy = 17'(r_py) - 17'($signed(r_rd_data[15:0]));
    assign ax = dx[16] ? 17'(-dx) : 17'(dx);
    assign ay = dy[16] ? 17'(-dy) : 17'(dy);

    // Squared distance against the squared radius.
    assign dist2 = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign hit   = (dist2 < {1'b0, r_limit});
    assign full  = (r_wr == CNT_W'(CAPACITY));

    // Memory write port: kept entries close up, the point goes to its slot.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_kind, r_wr[IDX_W-1:0]};
        mem_wdata = {r_px, r_py};
        case (i_ctrl.op)
            OP_DECIDE: begin
                if (!hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                end else if (!r_merged) begin
                    mem_we = 1'b1;
                end
            end
            OP_FINISH: begin
                mem_we = !r_merged && !full;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = {r_kind, r_rd[IDX_W-1:0]};

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_ctrl.op == OP_READ) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // Payload registers: request point, squares and the squared radius.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_kind <= i_kind;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
        end
        if (i_ctrl.op == OP_SETUP) begin
            r_limit <= r_merge_dist * r_merge_dist;
        end
        if (i_ctrl.op == OP_SQUARE) begin
            r_sq_x <= ax[15:0] * ax[15:0];
            r_sq_y <= ay[15:0] * ay[15:0];
        end
    end

    // Scan control, table counts, radius register and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_dist <= MERGE_DIST_RST;
            r_count[0]   <= '0;
            r_count[1]   <= '0;
            r_rd         <= '0;
            r_wr         <= '0;
            r_merged     <= 1'b0;
            r_slot       <= '0;
            r_removed    <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= (i_ctrl.op == OP_FINISH);
            if (i_cfg_wr_en) begin
                r_merge_dist <= i_cfg_wr_data;
            end
            case (i_ctrl.op)
                OP_SETUP: begin
                    r_rd      <= '0;
                    r_wr      <= '0;
                    r_merged  <= 1'b0;
                    r_slot    <= '0;
                    r_removed <= '0;
                end
                OP_DECIDE: begin
                    r_rd <= r_rd + CNT_W'(1);
                    if (!hit) begin
                        r_wr <= r_wr + CNT_W'(1);
                    end else if (!r_merged) begin
                        r_merged <= 1'b1;
                        r_slot   <= r_wr[IDX_W-1:0];
                        r_wr     <= r_wr + CNT_W'(1);
                    end else begin
                        r_removed <= r_removed + IDX_W'(1);
                    end
                end
                OP_FINISH: begin
                    r_out_merged  <= r_merged;
                    r_out_dropped <= !r_merged && full;
                    r_out_removed <= r_removed;
                    if (r_merged) begin
                        r_out_slot      <= r_slot;
                        r_count[r_kind] <= r_wr;
                        r_out_count     <= r_wr;
                    end else if (full) begin
                        r_out_slot  <= '0;
                        r_out_count <= r_wr;
                    end else begin
                        r_out_slot      <= r_wr[IDX_W-1:0];
                        r_count[r_kind] <= r_wr + CNT_W'(1);
                        r_out_count     <= r_wr + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields, cut or widened to the port widths.
    assign slot_pad    = {{SLOT_OUT_W{1'b0}}, r_out_slot};
    assign removed_pad = {{SLOT_OUT_W{1'b0}}, r_out_removed};
    assign count_pad   = {{CNT_OUT_W{1'b0}}, r_out_count};

    assign o_done         = r_done;
    assign o_merged       = r_out_merged;
    assign o_dropped_full = r_out_dropped;
    assign o_slot         = slot_pad[SLOT_OUT_W-1:0];
    assign o_removed      = removed_pad[SLOT_OUT_W-1:0];
    assign o_entry_count  = count_pad[CNT_OUT_W-1:0];

`ifndef SYNTHESIS
    // A result strobe follows only a finish step.
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_ctrl.op == OP_FINISH))
        else $error("result strobe without finish step");

    // A result is never both merged and dropped.
    a_merge_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_merged && o_dropped_full))
        else $error("result both merged and dropped");

    // Compaction never writes ahead of the read pointer.
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd)
        else $error("write pointer passed read pointer");

    // Neither table ever holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_W'(CAPACITY)) && (r_count[1] <= CNT_W'(CAPACITY)))
        else $error("table count above capacity");
`endif

endmodule

FILE: rtl/point_list_distance_merge_top.sv
// ---------------------------------------------------------------------------
// Point list distance merge, top level
// Keeps obstacle and hiker point tables and merges near-duplicate points.
// ---------------------------------------------------------------------------
// Usage:
//   A request (i_kind, i_pos_x, i_pos_y) is taken at a clock edge where
//   start is high and busy is low. i_kind selects the obstacle table (0) or
//   the hiker table (1); coordinates are signed Q8.8 feet.
//   The merge radius is written through i_cfg_wr_en / i_cfg_wr_data while
//   the block is idle; it resets to 1.5 ft.
//   Each request yields one result, shown for a single cycle with o_done
//   high. The receiver cannot hold results off.
//   After the accepting edge the sequencer runs a set-up step, then read,
//   square and compare steps for each stored entry (the read being
//   registered), then a finish step; an empty table goes straight from
//   set-up to finish. o_done is registered from the finish step. busy
//   stays high through the finish step and is low again in the o_done
//   cycle, so the next request can be taken at the edge that takes the
//   result; no new request is taken while one is still in progress.
//   Reset empties both tables; table contents need no clearing pass.
// ---------------------------------------------------------------------------
module point_list_distance_merge_top #(
    parameter int CAPACITY = plm_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_wr_en,
    input  logic [15:0]                    i_cfg_wr_data,
    input  logic                           i_kind,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    output logic                           o_done,
    output logic                           o_merged,
    output logic                           o_dropped_full,
    output logic [plm_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [plm_pkg::SLOT_OUT_W-1:0] o_removed,
    output logic [plm_pkg::CNT_OUT_W-1:0]  o_entry_count
);
    import plm_pkg::*;

    t_dp_ctrl   dp_ctrl;
    t_dp_status dp_status;

    // Microcode sequencer.
    plm_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_ctrl   (dp_ctrl),
        .o_busy   (busy)
    );

    // Tables, arithmetic and result registers.
    plm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (dp_ctrl),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_status       (dp_status),
        .o_done         (o_done),
        .o_merged       (o_merged),
        .o_dropped_full (o_dropped_full),
        .o_slot         (o_slot),
        .o_removed      (o_removed),
        .o_entry_count  (o_entry_count)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Point list distance merge testbench
// Drives point requests into the obstacle and hiker tables under several
// merge radii and sender idle patterns. A scoreboard predicts every merge,
// append, removal and drop, and checks each result field by field.
// ---------------------------------------------------------------------------
module testbench;
    import plm_pkg::*;

    localparam int RANDOM_PHASES  = 8;
    localparam int REQS_PER_PHASE = 138;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 60;

    // Outcome of one merge request, in the widths of the result ports.
    typedef struct packed {
        logic                  merged;
        logic                  dropped_full;
        logic [SLOT_OUT_W-1:0] slot;
        logic [SLOT_OUT_W-1:0] removed;
        logic [CNT_OUT_W-1:0]  entry_count;
    } merge_outcome_t;

    // Scoreboard: keeps its own copy of both point tables and the radius.
    class point_merge_tracker;
        logic [15:0]        radius;
        logic signed [15:0] tab_x [2][CAPACITY_DEF];
        logic signed [15:0] tab_y [2][CAPACITY_DEF];
        int                 fill [2];
        merge_outcome_t     outcomes [$];
        int                 mismatches;

        function new();
            radius     = MERGE_DIST_RST;
            fill[0]    = 0;
            fill[1]    = 0;
            mismatches = 0;
        endfunction

        // Applies an accepted request to the table copy and queues the outcome.
        function void note_request(logic kind, logic signed [15:0] x,
                                   logic signed [15:0] y);
            int             t;
            int             i;
            int             k;
            longint         dx;
            longint         dy;
            longint         lim;
            merge_outcome_t o;
            t   = int'(kind);
            o   = '0;
            i   = 0;
            lim = longint'(radius) * longint'(radius);
            while (i < fill[t]) begin
                dx = longint'(x) - longint'(tab_x[t][i]);
                dy = longint'(y) - longint'(tab_y[t][i]);
                if (dx * dx + dy * dy < lim) begin
                    if (!o.merged) begin
                        tab_x[t][i] = x;
                        tab_y[t][i] = y;
                        o.merged    = 1'b1;
                        o.slot      = SLOT_OUT_W'(i);
                        i++;
                    end else begin
                        // Stale duplicate: close the gap behind it.
                        for (k = i; k + 1 < fill[t]; k++) begin
                            tab_x[t][k] = tab_x[t][k + 1];
                            tab_y[t][k] = tab_y[t][k + 1];
                        end
                        fill[t]--;
                        o.removed++;
                    end
                end else begin
                    i++;
                end
            end
            if (!o.merged) begin
                if (fill[t] < CAPACITY_DEF) begin
                    tab_x[t][fill[t]] = x;
                    tab_y[t][fill[t]] = y;
                    o.slot            = SLOT_OUT_W'(fill[t]);
                    fill[t]++;
                end else begin
                    o.dropped_full = 1'b1;
                end
            end
            o.entry_count = CNT_OUT_W'(fill[t]);
            outcomes.insert(outcomes.size(), o);
        endfunction

        // Compares one result with the oldest outcome still waiting.
        function void check_outcome(merge_outcome_t got);
            merge_outcome_t want;
            if (outcomes.size() == 0) begin
                $error("unexpected result: merged=%0d dropped_full=%0d slot=%0d",
                       got.merged, got.dropped_full, got.slot);
                mismatches++;
                return;
            end
            want = outcomes.pop_front();
            if (got.merged !== want.merged) begin
                $error("merged: expected %0d, got %0d", want.merged, got.merged);
                mismatches++;
            end
            if (got.dropped_full !== want.dropped_full) begin
                $error("dropped_full: expected %0d, got %0d",
                       want.dropped_full, got.dropped_full);
                mismatches++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d, got %0d", want.slot, got.slot);
                mismatches++;
            end
            if (got.removed !== want.removed) begin
                $error("removed: expected %0d, got %0d", want.removed, got.removed);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                mismatches++;
            end
        endfunction

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [15:0]           i_cfg_wr_data  = '0;
    logic                  i_kind         = KIND_OBSTACLE;
    logic signed [15:0]    i_pos_x        = '0;
    logic signed [15:0]    i_pos_y        = '0;
    logic                  o_done;
    logic                  o_merged;
    logic                  o_dropped_full;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [SLOT_OUT_W-1:0] o_removed;
    logic [CNT_OUT_W-1:0]  o_entry_count;

    point_merge_tracker tracker;
    int                 cycle_count = 0;
    int                 center_x;
    int                 center_y;

    point_list_distance_merge_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_done         (o_done),
        .o_merged       (o_merged),
        .o_dropped_full (o_dropped_full),
        .o_slot         (o_slot),
        .o_removed      (o_removed),
        .o_entry_count  (o_entry_count)
    );

    // Clock generation.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result monitor and run timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            tracker.check_outcome('{o_merged, o_dropped_full, o_slot, o_removed,
                                    o_entry_count});
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one request and waits until it is taken. Start stays high so
    // that back-to-back requests need no gap; the caller lowers it.
    task automatic send_point(logic kind, logic signed [15:0] x,
                              logic signed [15:0] y);
        start   <= 1'b1;
        i_kind  <= kind;
        i_pos_x <= x;
        i_pos_y <= y;
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.note_request(kind, x, y);
    endtask

    // Stops requests and waits until every outcome has come back.
    task automatic drain_requests();
        start <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the merge radius; the block must be idle.
    task automatic set_merge_radius(logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        tracker.radius = value;
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Chooses a point: mostly close to a stored entry or inside a cluster,
    // so that merges and removals are frequent; the rest is spread wide.
    function automatic void pick_point(logic kind, output logic signed [15:0] x,
                                       output logic signed [15:0] y);
        int t;
        int pick;
        int near_span;
        int box;
        int idx;
        t         = int'(kind);
        pick      = $urandom_range(0, 99);
        near_span = (tracker.radius > 4088) ? 4096 : int'(tracker.radius) + 8;
        box       = (tracker.radius > 8160) ? 16384 : 2 * int'(tracker.radius) + 64;
        if (pick < 45 && tracker.fill[t] > 0) begin
            idx = $urandom_range(0, tracker.fill[t] - 1);
            x   = 16'(int'(tracker.tab_x[t][idx]) +
                      int'($urandom_range(0, 2 * near_span)) - near_span);
            y   = 16'(int'(tracker.tab_y[t][idx]) +
                      int'($urandom_range(0, 2 * near_span)) - near_span);
        end else if (pick < 75) begin
            x = 16'(center_x + int'($urandom_range(0, 2 * box)) - box);
            y = 16'(center_y + int'($urandom_range(0, 2 * box)) - box);
        end else if (pick < 92) begin
            x = 16'($urandom);
            y = 16'($urandom);
        end else begin
            x = 16'(extreme_coord());
            y = 16'(extreme_coord());
        end
    endfunction

    // Stimulus.
    initial begin
        logic [15:0]        phase_radius [RANDOM_PHASES];
        int                 idle_pct [RANDOM_PHASES];
        logic               kind;
        logic signed [15:0] px;
        logic signed [15:0] py;
        int                 p;
        int                 n;
        tracker      = new();
        phase_radius = '{16'd384, 16'd0, 16'd65535, 16'd1, 16'd700, 16'd0,
                         16'd2500, 16'd200};
        idle_pct     = '{0, 65, 0, 31, 65, 0, 31, 65};
        phase_radius[5] = 16'($urandom_range(0, 65535));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Appends, a merge at the default radius, and corner coordinates.
        send_point(KIND_OBSTACLE, 16'sd0, 16'sd0);
        send_point(KIND_OBSTACLE, 16'sd100, 16'sd0);
        send_point(KIND_OBSTACLE, -16'sd32768, -16'sd32768);
        send_point(KIND_OBSTACLE, 16'sd32767, 16'sd32767);
        send_point(KIND_HIKER, 16'sd32767, -16'sd32768);
        send_point(KIND_OBSTACLE, 16'sd1000, 16'sd0);
        send_point(KIND_OBSTACLE, -16'sd1000, 16'sd0);

        // Wider radius: one merge that also removes two later duplicates.
        drain_requests();
        set_merge_radius(16'd1500);
        send_point(KIND_OBSTACLE, 16'sd0, 16'sd0);

        // Zero radius never matches: fill the hiker table, then drop.
        drain_requests();
        set_merge_radius(16'd0);
        for (n = 0; n < CAPACITY_DEF; n++) begin
            send_point(KIND_HIKER, 16'sd0, 16'sd0);
        end

        // Largest radius: merge into the first entry and remove all others.
        drain_requests();
        set_merge_radius(16'hFFFF);
        send_point(KIND_HIKER, 16'sd0, 16'sd0);

        // Random phases, each with its own radius and sender idle rate.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_requests();
            set_merge_radius(phase_radius[p]);
            center_x = int'($urandom_range(0, 32768)) - 16384;
            center_y = int'($urandom_range(0, 32768)) - 16384;
            for (n = 0; n < REQS_PER_PHASE; n++) begin
                kind = 1'($urandom_range(0, 1));
                pick_point(kind, px, py);
                send_point(kind, px, py);
                if (int'($urandom_range(0, 99)) < idle_pct[p]) begin
                    start <= 1'b0;
                    if ($urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(13, 60)) @(posedge i_clk);
                    end else begin
                        repeat ($urandom_range(1, 12)) @(posedge i_clk);
                    end
                end
            end
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
